### rtl/core/pcrc_pkg.sv
// ----------------------------------------------------------------------------
// pcrc_pkg
// Types, constants and the CRC table function shared by the packet CRC-16
// checker.
// ----------------------------------------------------------------------------
package pcrc_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned CrcW       = 16;
  localparam int unsigned CountW     = 9;
  localparam int unsigned LenW       = CountW + 1;
  localparam int unsigned TrailDepth = 4;

  localparam logic [CountW-1:0] CountLimit     = '1;
  localparam logic [CountW-1:0] MinPacketBytes = CountW'(7);
  localparam logic [CrcW-1:0]   ReflectedPoly  = 16'h8408;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic            crc_ok;
    logic [CrcW-1:0] computed_crc;
    logic            length_error;
  } out_item_t;

  // One entry of the reflected-polynomial table, eight shift-and-xor steps.
  function automatic logic [CrcW-1:0] crc_table_entry(input logic [ByteW-1:0] idx);
    logic [CrcW-1:0] v;
    v = {{(CrcW-ByteW){1'b0}}, idx};
    for (int k = 0; k < ByteW; k++) begin
      if (v[0]) begin
        v = (v >> 1) ^ ReflectedPoly;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

  // MSB-first update that indexes the reflected table.
  function automatic logic [CrcW-1:0] crc_update(input logic [CrcW-1:0]  crc,
                                                 input logic [ByteW-1:0] b);
    logic [ByteW-1:0] idx;
    idx = crc[CrcW-1 -: ByteW] ^ b;
    return {crc[CrcW-ByteW-1:0], {ByteW{1'b0}}} ^ crc_table_entry(idx);
  endfunction

endpackage

### rtl/core/packet_crc16_checker.sv
// ----------------------------------------------------------------------------
// packet_crc16_checker
// Checks the 16-bit CRC carried in a received packet, one byte per item.
// ----------------------------------------------------------------------------
// The block takes one packet byte per clock cycle and gives one result item
// for each packet, registered when its final byte is accepted. The CRC covers
// bytes 3 through L-5 and is compared with bytes L-4 (high) and L-3 (low).
// Each byte passes through a single table lookup and XOR into the running
// CRC, so the input runs at one item per cycle unless it is stalled. The
// result sits in one output register; the input stalls only while that
// register is full and the downstream side stalls it.
module packet_crc16_checker #(
  parameter int unsigned MAX_PACKET_BYTES = 255
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pcrc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pcrc_pkg::out_item_t out_data
);
  import pcrc_pkg::*;

  logic [CrcW-1:0]   crc_acc_r,    crc_acc_nxt;
  logic [CountW-1:0] byte_count_r, byte_count_nxt;
  logic [ByteW-1:0]  trail_r   [TrailDepth];
  logic [ByteW-1:0]  trail_nxt [TrailDepth];
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              in_accept;
  logic              out_take;
  logic [CrcW-1:0]   crc_cov;
  logic [LenW-1:0]   pkt_len;
  logic              len_err;
  logic              crc_match;
  out_item_t         result;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;

  // A byte enters the CRC four items after it arrived, once it is byte 3 on.
  assign crc_cov = (byte_count_r >= MinPacketBytes)
                 ? crc_update(crc_acc_r, trail_r[TrailDepth-1]) : crc_acc_r;

  assign pkt_len   = {1'b0, byte_count_r} + LenW'(1);
  assign len_err   = (pkt_len < LenW'(MinPacketBytes)) ||
                     (pkt_len > LenW'(MAX_PACKET_BYTES));
  assign crc_match = (crc_cov[CrcW-1 -: ByteW] == trail_r[2]) &&
                     (crc_cov[ByteW-1:0] == trail_r[1]);

  always_comb begin
    result.crc_ok       = !len_err && crc_match;
    result.computed_crc = crc_cov;
    result.length_error = len_err;
  end

  always_comb begin
    crc_acc_nxt    = crc_acc_r;
    byte_count_nxt = byte_count_r;
    for (int i = 0; i < TrailDepth; i++) begin
      trail_nxt[i] = trail_r[i];
    end
    if (in_accept) begin
      if (in_data.last) begin
        // End of packet: the CRC, byte count and trail return to their reset values.
        crc_acc_nxt    = '0;
        byte_count_nxt = '0;
        for (int i = 0; i < TrailDepth; i++) begin
          trail_nxt[i] = '0;
        end
      end else begin
        crc_acc_nxt  = crc_cov;
        trail_nxt[0] = in_data.data_byte;
        for (int i = 1; i < TrailDepth; i++) begin
          trail_nxt[i] = trail_r[i-1];
        end
        if (byte_count_r != CountLimit) begin
          byte_count_nxt = byte_count_r + CountW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_acc_r    <= '0;
      byte_count_r <= '0;
      for (int i = 0; i < TrailDepth; i++) begin
        trail_r[i] <= '0;
      end
      out_valid_r  <= 1'b0;
    end else begin
      crc_acc_r    <= crc_acc_nxt;
      byte_count_r <= byte_count_nxt;
      for (int i = 0; i < TrailDepth; i++) begin
        trail_r[i] <= trail_nxt[i];
      end
      if (in_accept && in_data.last) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_data.last) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_data.last |=> out_valid_r)
    else $error("final byte accepted without a result");

  a_body_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && !in_data.last |=> !out_valid_r)
    else $error("result appeared for a non-final byte");

  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_data.last |=> (crc_acc_r == '0) && (byte_count_r == '0))
    else $error("packet state not cleared after final byte");

  a_ok_needs_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.crc_ok && out_data_r.length_error))
    else $error("CRC match reported on a packet with a length error");

endmodule
